// ----- src/scdw_pkg.sv -----
// ----------------------------------------------------------------------------
// scdw_pkg: shared types and constants for the scaled serial DAC writer
// Field widths, register indexes, reset values and the word record that
// travels from the scaling front end to the serializer.
// ----------------------------------------------------------------------------
package scdw_pkg;

   localparam int VALUE_W = 16;
   localparam int CODE_W  = 16;
   localparam int PROD_W  = 32;
   localparam int IDX_W   = 4;
   localparam int CSR_AW  = 2;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_SCALE_MULT    = 2'd0;
   localparam logic [CSR_AW-1:0] REG_SCALE_DIV     = 2'd1;
   localparam logic [CSR_AW-1:0] REG_CLAMP_LIMIT_A = 2'd2;
   localparam logic [CSR_AW-1:0] REG_CLAMP_LIMIT_B = 2'd3;

   // Reset values
   localparam logic [VALUE_W-1:0] RST_SCALE_MULT    = 16'd4096;
   localparam logic [VALUE_W-1:0] RST_SCALE_DIV     = 16'd5000;
   localparam logic [VALUE_W-1:0] RST_CLAMP_LIMIT_A = 16'd4295;
   localparam logic [VALUE_W-1:0] RST_CLAMP_LIMIT_B = 16'd4095;

   // Queue between front end and serializer
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [VALUE_W-1:0] scale_mult;
      logic [VALUE_W-1:0] scale_div;
      logic [VALUE_W-1:0] clamp_limit_a;
      logic [VALUE_W-1:0] clamp_limit_b;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              target;
   } word_type;

endpackage

// ----- src/scdw_ifs.sv -----
// ----------------------------------------------------------------------------
// scdw channel interfaces
// Valid/ready channels for requests, serial bit results and register writes.
// ----------------------------------------------------------------------------
interface scdw_req_if
   import scdw_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] dac_value;
   logic               channel;

   modport source (output valid, dac_value, channel, input ready);
   modport sink   (input valid, dac_value, channel, output ready);
endinterface

interface scdw_rsp_if
   import scdw_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              data_bit;
   logic [IDX_W-1:0]  bit_index;
   logic              target;
   logic [CODE_W-1:0] code;
   logic              last;

   modport source (output valid, data_bit, bit_index, target, code, last, input ready);
   modport sink   (input valid, data_bit, bit_index, target, code, last, output ready);
endinterface

interface scdw_csr_if
   import scdw_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [CSR_AW-1:0]  index;
   logic [VALUE_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/scdw_front.sv -----
// ----------------------------------------------------------------------------
// scdw_front: request intake and scaling
// Holds one request, multiplies by the scale factor, divides with a
// bit-per-cycle restoring divider (skipped for a zero divisor), clamps and pushes the code word.
// ----------------------------------------------------------------------------
module scdw_front
   import scdw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   scdw_req_if.sink  req_ch,
   input  cfg_type   cfg,
   output logic      push_valid,
   input  logic      push_ready,
   output word_type  push_word
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;
   localparam int STEP_W = $clog2(PROD_W);

   logic [1:0]         state_ff, state_in;
   logic               hold_valid_ff, hold_valid_in;
   logic [VALUE_W-1:0] hold_value_ff;
   logic               hold_chan_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [PROD_W-1:0]  quo_ff;
   logic [VALUE_W-1:0] rem_ff;
   logic [VALUE_W-1:0] div_ff;
   logic [CODE_W-1:0]  limit_ff;
   logic               target_ff;

   logic               hold_take;
   logic               req_fire;
   logic [PROD_W-1:0]  product;
   logic [CODE_W-1:0]  limit_sel;
   logic [VALUE_W:0]   rem_shift;
   logic               sub_ok;
   logic [VALUE_W:0]   rem_diff;
   logic               over;

   assign hold_take    = (state_ff == ST_IDLE) && hold_valid_ff;
   assign req_ch.ready = !hold_valid_ff || hold_take;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign hold_valid_in = req_fire || (hold_valid_ff && !hold_take);

   assign product   = PROD_W'(hold_value_ff) * PROD_W'(cfg.scale_mult);
   assign limit_sel = hold_chan_ff ? cfg.clamp_limit_b : cfg.clamp_limit_a;

   // One restoring divide step
   assign rem_shift = {rem_ff, quo_ff[PROD_W-1]};
   assign sub_ok    = rem_shift >= {1'b0, div_ff};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   assign over = (|quo_ff[PROD_W-1:CODE_W]) || (quo_ff[CODE_W-1:0] > limit_ff);

   assign push_valid       = (state_ff == ST_PUSH);
   assign push_word.code   = over ? limit_ff : quo_ff[CODE_W-1:0];
   assign push_word.target = target_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (hold_valid_ff) begin
               state_in = (cfg.scale_div == '0) ? ST_PUSH : ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_value_ff <= req_ch.dac_value;
         hold_chan_ff  <= req_ch.channel;
      end
      if (hold_take) begin
         // zero divisor: load the limit so the clamp passes it through
         quo_ff    <= (cfg.scale_div == '0) ? PROD_W'(limit_sel) : product;
         rem_ff    <= '0;
         div_ff    <= cfg.scale_div;
         limit_ff  <= limit_sel;
         target_ff <= hold_chan_ff;
         step_ff   <= '0;
      end else if (state_ff == ST_DIV) begin
         quo_ff  <= {quo_ff[PROD_W-2:0], sub_ok};
         rem_ff  <= sub_ok ? rem_diff[VALUE_W-1:0] : rem_shift[VALUE_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

endmodule

// ----- src/scdw_queue.sv -----
// ----------------------------------------------------------------------------
// scdw_queue: short word queue
// Two-entry FIFO between the scaling front end and the serializer.
// ----------------------------------------------------------------------------
module scdw_queue
   import scdw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  word_type push_word,
   output logic     pop_valid,
   input  logic     pop_ready,
   output word_type pop_word
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   word_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              wr_fire;
   logic              rd_fire;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign wr_fire    = push_valid && push_ready;
   assign rd_fire    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_fire && !rd_fire) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_fire && !wr_fire) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_fire) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- src/scdw_back.sv -----
// ----------------------------------------------------------------------------
// scdw_back: serializer
// Shifts each code word out MSB first, one result item per bit, from a
// registered output stage.
// ----------------------------------------------------------------------------
module scdw_back
   import scdw_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  word_type   pop_word,
   scdw_rsp_if.source rsp_ch
);

   localparam int POS_W = $clog2(WORD_BITS);

   logic                 active_ff, active_in;
   logic [WORD_BITS-1:0] shift_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [CODE_W-1:0]    code_ff;
   logic                 target_ff;
   logic                 advance;
   logic                 finish;
   logic                 load;

   assign advance   = active_ff && rsp_ch.ready;
   assign finish    = advance && (pos_ff == '0);
   assign pop_ready = !active_ff || finish;
   assign load      = pop_valid && pop_ready;
   assign active_in = load || (active_ff && !finish);

   assign rsp_ch.valid     = active_ff;
   assign rsp_ch.data_bit  = shift_ff[WORD_BITS-1];
   assign rsp_ch.bit_index = IDX_W'(pos_ff);
   assign rsp_ch.target    = target_ff;
   assign rsp_ch.code      = code_ff;
   assign rsp_ch.last      = (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff  <= WORD_BITS'(pop_word.code);
         pos_ff    <= POS_W'(WORD_BITS - 1);
         code_ff   <= pop_word.code;
         target_ff <= pop_word.target;
      end else if (advance) begin
         shift_ff <= {shift_ff[WORD_BITS-2:0], 1'b0};
         pos_ff   <= pos_ff - 1'b1;
      end
   end

endmodule

// ----- src/scaled_dac_serial_writer.sv -----
// ----------------------------------------------------------------------------
// scaled_dac_serial_writer: scaled and clamped serial DAC word writer
// Scales a requested value, clamps it per channel and streams the code
// word out one bit per result item.
// ----------------------------------------------------------------------------
// Each request (dac_value, channel) becomes code = min(dac_value * scale_mult
// / scale_div, limit of the channel), or the limit itself when scale_div is
// zero, and is then sent as WORD_BITS result items, MSB first, each carrying
// the bit, its position (mod 16), the channel as target, the full code and a
// last flag on position 0. The front end multiplies, divides one quotient
// bit per cycle in the restoring divider (skipped with a zero divisor) and
// pushes; the serializer shifts the word out, holding each bit while rsp_ch
// is not ready. The two run concurrently through a two-entry queue. A
// request is taken into a holding register while the previous one is still
// dividing. Registers are written through csr_ch, which is always ready;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module scaled_dac_serial_writer
   import scdw_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   scdw_req_if.sink   req_ch,
   scdw_rsp_if.source rsp_ch,
   scdw_csr_if.sink   csr_ch
);

   cfg_type  cfg_ff;
   logic     csr_fire;

   logic     push_valid;
   logic     push_ready;
   word_type push_word;
   logic     pop_valid;
   logic     pop_ready;
   word_type pop_word;

   // Configuration registers: always ready, unknown indexes drop
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_mult    <= RST_SCALE_MULT;
         cfg_ff.scale_div     <= RST_SCALE_DIV;
         cfg_ff.clamp_limit_a <= RST_CLAMP_LIMIT_A;
         cfg_ff.clamp_limit_b <= RST_CLAMP_LIMIT_B;
      end else if (csr_fire) begin
         case (csr_ch.index)
            REG_SCALE_MULT:    cfg_ff.scale_mult    <= csr_ch.data;
            REG_SCALE_DIV:     cfg_ff.scale_div     <= csr_ch.data;
            REG_CLAMP_LIMIT_A: cfg_ff.clamp_limit_a <= csr_ch.data;
            REG_CLAMP_LIMIT_B: cfg_ff.clamp_limit_b <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // Front end: hold the request, scale, divide, clamp
   scdw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   // Queue: decouple divider from serializer
   scdw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   // Back end: shift the word out, one item per bit
   scdw_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_word  (pop_word),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- src/scdw_checker.sv -----
// ----------------------------------------------------------------------------
// scdw_checker: port-level checks on the result stream
// Watches the serial result channel for word framing and hold behavior.
// ----------------------------------------------------------------------------
module scdw_checker
   import scdw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              data_bit,
   input logic [IDX_W-1:0]  bit_index,
   input logic              target,
   input logic [CODE_W-1:0] code,
   input logic              last
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_bit) && $stable(bit_index)
         && $stable(code) && $stable(last))
      else $error("result changed while stalled");

   // Within a word the next bit follows at once, one position lower
   a_bit_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> rsp_valid && (bit_index == $past(bit_index) - 4'd1))
      else $error("bit position did not step down");

   // Code and target stay fixed across a word
   a_word_const: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> (code == $past(code)) && (target == $past(target)))
      else $error("code or target changed inside a word");

   // The final bit is position zero
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last |-> bit_index == '0)
      else $error("last flagged away from position zero");

endmodule

bind scaled_dac_serial_writer scdw_checker u_scdw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .data_bit  (rsp_ch.data_bit),
   .bit_index (rsp_ch.bit_index),
   .target    (rsp_ch.target),
   .code      (rsp_ch.code),
   .last      (rsp_ch.last)
);
